// ===== src/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search: shared definitions
// Table geometry, field widths, request codes and the microcode format of
// the search sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

  // Table geometry.
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Request and response field widths.
  localparam int unsigned CMD_W     = 1;
  localparam int unsigned ENT_IDX_W = 10;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned RSTART_W  = 10;
  localparam int unsigned REND_W    = 11;

  // Search bounds are signed and must hold -1, the table depth itself and
  // any range_start or range_end a request can carry.
  localparam int unsigned BND_W = ((TBL_AW + 2) > REND_W) ? (TBL_AW + 2) : REND_W;

  typedef logic        [TBL_AW-1:0] tbl_addr_t;
  typedef logic signed [BND_W-1:0]  bound_t;
  typedef logic signed [WORD_W-1:0] word_t;

  // Request command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

  // Sequencer step addresses.
  typedef logic [1:0] step_t;
  localparam step_t STEP_IDLE  = 2'd0;
  localparam step_t STEP_START = 2'd1;
  localparam step_t STEP_PROBE = 2'd2;
  localparam step_t STEP_DONE  = 2'd3;

  // Datapath operation selected by a control word.
  typedef enum logic [1:0] {
    DP_NOP,
    DP_START,
    DP_PROBE
  } dp_op_e;

  // Branch condition of a control word.
  typedef enum logic [1:0] {
    COND_NEVER,
    COND_SEARCH_ACC,
    COND_MORE,
    COND_RSP_TAKEN
  } cond_e;

  typedef struct packed {
    logic   in_rdy;
    logic   out_vld;
    dp_op_e dp_op;
    cond_e  cond;
    step_t  jump_tgt;
    step_t  seq_next;
  } ctrl_t;

  typedef struct packed {
    logic search_acc;
    logic rsp_taken;
    logic more;
  } status_t;

  // Microcode store: one control word per step.
  function automatic ctrl_t ucode_rom(step_t step);
    ctrl_t cw;
    cw = '{in_rdy: 1'b0, out_vld: 1'b0, dp_op: DP_NOP, cond: COND_NEVER,
           jump_tgt: STEP_IDLE, seq_next: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        cw.in_rdy   = 1'b1;
        cw.cond     = COND_SEARCH_ACC;
        cw.jump_tgt = STEP_START;
        cw.seq_next = STEP_IDLE;
      end
      STEP_START: begin
        cw.dp_op    = DP_START;
        cw.cond     = COND_MORE;
        cw.jump_tgt = STEP_PROBE;
        cw.seq_next = STEP_DONE;
      end
      STEP_PROBE: begin
        cw.dp_op    = DP_PROBE;
        cw.cond     = COND_MORE;
        cw.jump_tgt = STEP_PROBE;
        cw.seq_next = STEP_DONE;
      end
      STEP_DONE: begin
        cw.out_vld  = 1'b1;
        cw.cond     = COND_RSP_TAKEN;
        cw.jump_tgt = STEP_IDLE;
        cw.seq_next = STEP_DONE;
      end
      default: begin
        cw.seq_next = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ===== src/stbs_if.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search: channel interfaces
// Valid/ready request channel (table writes and searches) and response
// channel (search result).
// ----------------------------------------------------------------------------
`default_nettype none

interface stbs_req_if;
  import stbs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic [ENT_IDX_W-1:0]       entry_index;
  logic signed [WORD_W-1:0]   entry_value;
  logic [RSTART_W-1:0]        range_start;
  logic signed [REND_W-1:0]   range_end;
  logic signed [WORD_W-1:0]   search_key;

  modport source (
    output valid, cmd, entry_index, entry_value, range_start, range_end, search_key,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_index, entry_value, range_start, range_end, search_key,
    output ready
  );
endinterface

interface stbs_rsp_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, found, input ready);
  modport sink   (input valid, found, output ready);
endinterface

`default_nettype wire

// ===== src/stbs_seq.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search: microcode sequencer
// Step counter over the control store, with one conditional jump per step.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stbs_pkg::status_t status_i,
  output stbs_pkg::ctrl_t   ctrl_o
);
  import stbs_pkg::*;

  step_t step_q;
  step_t step_d;
  ctrl_t cw;
  logic  take_jump;

  assign cw     = ucode_rom(step_q);
  assign ctrl_o = cw;

  always_comb begin
    case (cw.cond)
      COND_SEARCH_ACC: take_jump = status_i.search_acc;
      COND_MORE:       take_jump = status_i.more;
      COND_RSP_TAKEN:  take_jump = status_i.rsp_taken;
      default:         take_jump = 1'b0;
    endcase
    step_d = take_jump ? cw.jump_tgt : cw.seq_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search
// A table of signed 32-bit words loaded by write requests, and a binary
// search over an inclusive index range driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// A write request is taken while the sequencer idles, and the block stays ready.
// A search request passes through the start step, one probe step per probe (at
// most 11 probes for a 1024-entry table) and the done step, which presents the
// response and holds it until taken; no new request is taken before then. The
// single table read port sets the pace: one probe per cycle.
// Reset clears the sequencer only; the table holds no defined value until written.
`default_nettype none

module sorted_table_binary_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  stbs_req_if.sink    req_i,
  stbs_rsp_if.source  rsp_o
);
  import stbs_pkg::*;

  // Control from the sequencer and status back to it.
  ctrl_t   ctrl;
  status_t status;

  // Table storage with a registered read port.
  logic [WORD_W-1:0] tbl_mem [TABLE_DEPTH];
  word_t             rdata_q;

  // Search state: current bounds, last probed index, key and result.
  bound_t lo_q;
  bound_t hi_q;
  bound_t mid_q;
  word_t  key_q;
  logic   found_q;

  logic      req_acc;
  logic      wr_en;
  tbl_addr_t wr_addr;
  bound_t    req_lo;
  bound_t    req_end;
  bound_t    req_hi;
  bound_t    cur_lo;
  bound_t    cur_hi;
  logic      hit;
  logic      more;
  logic signed [BND_W:0] bnd_sum;
  bound_t    probe_mid;
  tbl_addr_t rd_addr;

  stbs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // Handshakes. The block takes a request only while the sequencer idles,
  // and presents the response from the done step.
  assign req_i.ready = ctrl.in_rdy;
  assign rsp_o.valid = ctrl.out_vld;
  assign rsp_o.found = found_q;

  assign req_acc = req_i.valid & req_i.ready;

  assign status.search_acc = req_acc & (req_i.cmd == CMD_SEARCH);
  assign status.rsp_taken  = rsp_o.valid & rsp_o.ready;
  assign status.more       = more;

  // A write beyond the table is dropped.
  assign wr_en   = req_acc & (req_i.cmd == CMD_WRITE) &
                   (32'(req_i.entry_index) < TABLE_DEPTH);
  assign wr_addr = tbl_addr_t'(req_i.entry_index);

  // Request bounds: the start is unsigned, the end is signed and saturates
  // at the last table entry. A negative end makes the range empty.
  assign req_lo  = bound_t'({1'b0, req_i.range_start});
  assign req_end = bound_t'(req_i.range_end);
  assign req_hi  = (req_end > bound_t'(TABLE_DEPTH - 1)) ? bound_t'(TABLE_DEPTH - 1) : req_end;

  // Bound update. The start step checks the loaded range; a probe step
  // compares the word read for the previous midpoint with the key and stops on
  // a match or keeps the lower or the upper half. The next midpoint is read at
  // once when no match was found and the remaining range is not empty.
  always_comb begin
    cur_lo = lo_q;
    cur_hi = hi_q;
    hit    = 1'b0;
    case (ctrl.dp_op)
      DP_PROBE: begin
        if (rdata_q == key_q) begin
          hit = 1'b1;
        end else if (rdata_q > key_q) begin
          cur_hi = mid_q - bound_t'(1);
        end else begin
          cur_lo = mid_q + bound_t'(1);
        end
      end
      default: begin
        cur_lo = lo_q;
        cur_hi = hi_q;
      end
    endcase
  end

  // Both bounds are non-negative whenever the range is not empty, so the
  // floor of their mean is the midpoint rounded down.
  assign bnd_sum   = {cur_lo[BND_W-1], cur_lo} + {cur_hi[BND_W-1], cur_hi};
  assign probe_mid = bnd_sum[BND_W:1];
  assign rd_addr   = probe_mid[TBL_AW-1:0];
  assign more      = ((ctrl.dp_op == DP_START) || (ctrl.dp_op == DP_PROBE)) &&
                     !hit && (cur_lo <= cur_hi);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= req_i.entry_value;
    end
    if (more) begin
      rdata_q <= tbl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.search_acc) begin
      lo_q  <= req_lo;
      hi_q  <= req_hi;
      key_q <= req_i.search_key;
    end
    if ((ctrl.dp_op == DP_START) || (ctrl.dp_op == DP_PROBE)) begin
      lo_q  <= cur_lo;
      hi_q  <= cur_hi;
      mid_q <= probe_mid;
    end
    if (ctrl.dp_op == DP_START) begin
      found_q <= 1'b0;
    end else if (hit) begin
      found_q <= 1'b1;
    end
  end

  // A search request always enters the start step next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.search_acc |=> (ctrl.dp_op == DP_START))
    else $error("search request did not start the sequencer");

  // Every probe address lies inside the range that is still open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    more |-> ((probe_mid >= cur_lo) && (probe_mid <= cur_hi) && (probe_mid >= bound_t'(0))))
    else $error("probe midpoint outside the search range");

  // No request is taken while a response is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !req_i.ready)
    else $error("request taken while a response is pending");

  // An equal probe ends the search with found set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |=> (rsp_o.valid && found_q))
    else $error("matching probe did not report found");

endmodule

`default_nettype wire

// ===== tb/sorted_table_binary_search_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted table binary search: block-level test
// Loads the table through write requests and sends search requests over
// inclusive index ranges. The bench keeps its own copy of the table and its
// own binary search, and checks each search response against it. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------

module sorted_table_binary_search_test;
  import stbs_pkg::*;

  // Run length and limits.
  localparam int unsigned RANDOM_ITEMS   = 1600;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t WORD_MAX = 32'sh7fff_ffff;

  // One request as it goes on the wire. A write ignores the search fields and
  // a search ignores the write fields.
  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic [ENT_IDX_W-1:0]     entry_index;
    word_t                    entry_value;
    logic [RSTART_W-1:0]      range_start;
    logic signed [REND_W-1:0] range_end;
    word_t                    search_key;
  } stbs_req_t;

  // A row of the directed table. Where typed is set, found is the answer
  // written down by hand; otherwise the bench's own search decides.
  typedef struct {
    stbs_req_t req;
    bit        typed;
    logic      found;
  } dir_row_t;

  // Ready patterns of the response side.
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PATTERN
  } rsp_stall_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  stbs_req_if req_if ();
  stbs_rsp_if rsp_if ();

  sorted_table_binary_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bench copy of the table and the answers still owed by the block, oldest
  // first.
  word_t       table_model [TABLE_DEPTH];
  logic        pending_found_q [$];

  // Window of the sorted run loaded last; well-formed searches stay inside it.
  int          win_lo;
  int          win_hi;

  // Requests left in the current sender burst.
  int unsigned burst_left = 0;

  int unsigned n_sent      = 0;
  int unsigned n_writes    = 0;
  int unsigned n_searches  = 0;
  int unsigned n_hits      = 0;
  int unsigned n_empty     = 0;
  int unsigned max_probes  = 0;
  int unsigned n_responses = 0;
  int unsigned fail_count  = 0;

  // --------------------------------------------------------------------------
  // Binary search over the bench copy of the table. The range end saturates to
  // the last table entry, an empty range costs no probe, and the midpoint
  // rounds down. An unsorted table is searched the same way; the answer is
  // whatever those probes give. Every entry a search can touch has been
  // written before, so the copy is never read where the block holds garbage.
  // --------------------------------------------------------------------------
  function automatic logic search_table(int lo, int hi, word_t key,
                                        output int unsigned probes);
    int mid;
    probes = 0;
    if (hi > int'(TABLE_DEPTH) - 1) hi = int'(TABLE_DEPTH) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      probes++;
      if (table_model[mid] == key) return 1'b1;
      if (table_model[mid] > key) hi = mid - 1;
      else lo = mid + 1;
    end
    return 1'b0;
  endfunction

  // Fields that the command ignores still get random values, so that every
  // bit of the request toggles.
  function automatic stbs_req_t make_write(int idx, word_t value);
    stbs_req_t r;
    r.cmd         = CMD_WRITE;
    r.entry_index = ENT_IDX_W'(idx);
    r.entry_value = value;
    r.range_start = RSTART_W'($urandom);
    r.range_end   = REND_W'($urandom);
    r.search_key  = $urandom;
    return r;
  endfunction

  function automatic stbs_req_t make_search(int lo, int hi, word_t key);
    stbs_req_t r;
    r.cmd         = CMD_SEARCH;
    r.entry_index = ENT_IDX_W'($urandom);
    r.entry_value = $urandom;
    r.range_start = RSTART_W'(lo);
    r.range_end   = REND_W'(hi);
    r.search_key  = key;
    return r;
  endfunction

  function automatic dir_row_t dir_write(int idx, word_t value);
    dir_row_t row;
    row.req   = make_write(idx, value);
    row.typed = 1'b0;
    row.found = 1'b0;
    return row;
  endfunction

  function automatic dir_row_t dir_search(int lo, int hi, word_t key);
    dir_row_t row;
    row.req   = make_search(lo, hi, key);
    row.typed = 1'b0;
    row.found = 1'b0;
    return row;
  endfunction

  function automatic dir_row_t dir_search_exp(int lo, int hi, word_t key, logic found);
    dir_row_t row;
    row.req   = make_search(lo, hi, key);
    row.typed = 1'b1;
    row.found = found;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. The sender works in bursts: at the start of each burst valid
  // drops for a random gap, mostly short and now and then long. Inputs change
  // on the falling edge only; a request counts as taken at the first rising
  // edge that sees valid and ready together. Valid stays high from one
  // request to the next within a burst, so it gets one assignment per step.
  // --------------------------------------------------------------------------
  task automatic send_req(input stbs_req_t r, input bit typed, input logic typed_found);
    int unsigned probes;
    int unsigned gap;
    logic        hit;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    req_if.valid       <= 1'b1;
    req_if.cmd         <= r.cmd;
    req_if.entry_index <= r.entry_index;
    req_if.entry_value <= r.entry_value;
    req_if.range_start <= r.range_start;
    req_if.range_end   <= r.range_end;
    req_if.search_key  <= r.search_key;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    n_sent++;
    if (r.cmd == CMD_WRITE) begin
      // Every index a 10-bit field can name lies inside the table.
      table_model[r.entry_index] = r.entry_value;
      n_writes++;
    end else begin
      hit = search_table(int'(r.range_start), int'(r.range_end), r.search_key, probes);
      if (typed) hit = typed_found;
      pending_found_q.push_back(hit);
      n_searches++;
      if (hit) n_hits++;
      if (probes == 0) n_empty++;
      if (probes > max_probes) max_probes = probes;
    end
  endtask

  // Drop valid and hold off until every search sent so far has been answered.
  task automatic drain_pause();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_found_q.size() != 0) @(posedge clk_i);
  endtask

  // Write a sorted run of random words into table[lo..hi], in ascending or
  // descending index order. The start value and step size are chosen so that
  // the run never wraps; a small step size gives runs of equal words.
  task automatic load_sorted_run(input int lo, input int hi);
    word_t           run_vals [$];
    longint          max_step;
    longint          room;
    longint          v;
    longint unsigned r64;
    int              n;
    int              i;
    n        = hi - lo + 1;
    max_step = ((longint'(1) << 32) - 1) / n;
    max_step = max_step >> $urandom_range(0, 28);
    room     = (longint'(1) << 32) - max_step * (n - 1);
    r64      = {$urandom, $urandom};
    v        = longint'(r64 % room) - (longint'(1) << 31);
    repeat (n) begin
      run_vals.push_back(32'(v));
      v += longint'($urandom_range(0, 32'(max_step)));
    end
    win_lo = lo;
    win_hi = hi;
    if ($urandom_range(0, 1) == 0) begin
      for (i = 0; i < n; i++) send_req(make_write(lo + i, run_vals[i]), 1'b0, 1'b0);
    end else begin
      for (i = n - 1; i >= 0; i--) send_req(make_write(lo + i, run_vals[i]), 1'b0, 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: reset, the directed table, then random rounds. The first random
  // round loads the whole table, so no later search can reach an entry that
  // was never written. Each later round may reload a short sorted window and
  // then sends a mix of requests: mostly well-formed searches inside that
  // window, then empty ranges, searches over any range of a table that is no
  // longer sorted as a whole, and stray writes that break the order.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    rows [$];
    stbs_req_t   req;
    word_t       key;
    int          lo;
    int          hi;
    int          len;
    int          pick;
    int          sel;
    int unsigned rand_base;

    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.cmd         = CMD_WRITE;
    req_if.entry_index = '0;
    req_if.entry_value = '0;
    req_if.range_start = '0;
    req_if.range_end   = '0;
    req_if.search_key  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Nothing is written yet: empty ranges answer at once, with no probe.
    rows.push_back(dir_search_exp(0, -1, 32'sd0, 1'b0));
    rows.push_back(dir_search_exp(1023, -1024, WORD_MIN, 1'b0));
    rows.push_back(dir_search_exp(5, 4, WORD_MAX, 1'b0));
    // Extreme words at both ends of the table.
    rows.push_back(dir_write(0, WORD_MIN));
    rows.push_back(dir_write(1023, WORD_MAX));
    rows.push_back(dir_search_exp(0, 0, WORD_MIN, 1'b1));
    rows.push_back(dir_search_exp(0, 0, WORD_MAX, 1'b0));
    rows.push_back(dir_search_exp(1023, 1023, WORD_MAX, 1'b1));
    rows.push_back(dir_search_exp(1023, 1023, WORD_MIN, 1'b0));
    rows.push_back(dir_search_exp(1023, 1022, WORD_MAX, 1'b0));
    // A short sorted run across the sign boundary.
    rows.push_back(dir_write(1, -32'sd1));
    rows.push_back(dir_write(2, 32'sd0));
    rows.push_back(dir_write(3, 32'sd1));
    rows.push_back(dir_search(0, 3, 32'sd0));
    rows.push_back(dir_search(0, 3, 32'sd2));
    rows.push_back(dir_search(1, 3, WORD_MIN));
    rows.push_back(dir_search(0, 3, -32'sd1));
    // Alternating bit patterns in index and word.
    rows.push_back(dir_write(682, 32'sh2AAA_AAAA));
    rows.push_back(dir_search_exp(682, 682, 32'sh2AAA_AAAA, 1'b1));
    rows.push_back(dir_write(341, 32'shD555_5555));
    rows.push_back(dir_search_exp(341, 341, 32'shD555_5555, 1'b1));
    // An unsorted table: the probes decide, not the contents.
    rows.push_back(dir_write(2, 32'sd100));
    rows.push_back(dir_search(0, 3, 32'sd1));
    rows.push_back(dir_search(0, 3, 32'sd100));
    foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].found);

    // The sender waits for the block to answer everything at least here.
    drain_pause();

    rand_base = n_sent;
    load_sorted_run(0, int'(TABLE_DEPTH) - 1);
    while (n_sent - rand_base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) drain_pause();
      pick = $urandom_range(0, 7);
      if (pick < 5) begin
        len = (pick == 0) ? $urandom_range(33, 256) : $urandom_range(1, 32);
        lo  = $urandom_range(0, TABLE_DEPTH - len);
        load_sorted_run(lo, lo + len - 1);
      end
      repeat ($urandom_range(6, 24)) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          // Well-formed search inside the sorted window.
          lo = ($urandom_range(0, 1) == 0) ? win_lo : $urandom_range(win_lo, win_hi);
          hi = ($urandom_range(0, 1) == 0) ? win_hi : $urandom_range(lo, win_hi);
          sel = $urandom_range(0, 99);
          if (sel < 50) begin
            key = table_model[$urandom_range(lo, hi)];
          end else if (sel < 65) begin
            key = table_model[$urandom_range(lo, hi)] + (($urandom_range(0, 1) == 0) ? 1 : -1);
          end else if (sel < 85) begin
            key = $urandom;
          end else begin
            case ($urandom_range(0, 3))
              0:       key = WORD_MIN;
              1:       key = WORD_MAX;
              2:       key = 32'sd0;
              default: key = -32'sd1;
            endcase
          end
          req = make_search(lo, hi, key);
        end else if (pick < 75) begin
          // Empty range: the end lies below the start, negative ends included.
          lo = $urandom_range(0, TABLE_DEPTH - 1);
          if ($urandom_range(0, 1) == 0) hi = -1 - int'($urandom_range(0, 1023));
          else hi = int'($urandom_range(0, lo)) - 1;
          req = make_search(lo, hi, $urandom);
        end else if (pick < 87) begin
          // Any start, any end of the 11-bit field, over the whole table.
          lo  = $urandom_range(0, TABLE_DEPTH - 1);
          hi  = int'($urandom_range(0, 2047)) - 1024;
          key = ($urandom_range(0, 1) == 0) ? table_model[$urandom_range(0, TABLE_DEPTH - 1)]
                                            : word_t'($urandom);
          req = make_search(lo, hi, key);
        end else begin
          // Stray write anywhere in the table.
          req = make_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
        end
        send_req(req, 1'b0, 1'b0);
      end
    end

    // All requests are in: wait for the last answers, then let the block
    // settle long enough for a spurious response to show up.
    drain_pause();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests: %0d table writes and %0d searches.",
             n_sent, n_writes, n_searches);
    $display("Searches: %0d found, %0d empty ranges, up to %0d probes; %0d responses checked.",
             n_hits, n_empty, max_probes, n_responses);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response side. Ready changes on the falling edge and follows a pattern
  // picked at random, and picked anew when its run ends: always ready, a coin
  // toss, mostly stalled, or a rotating 8-bit mask.
  // --------------------------------------------------------------------------
  initial begin : response_stall
    int unsigned mode_left;
    rsp_stall_e  mode;
    logic [7:0]  mask;
    rsp_if.ready = 1'b0;
    mode_left    = 0;
    mode         = RDY_ALWAYS;
    mask         = 8'hff;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = rsp_stall_e'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
        mask      = 8'($urandom) | 8'h01;
      end
      mode_left--;
      mask = {mask[6:0], mask[7]};
      case (mode)
        RDY_ALWAYS: rsp_if.ready <= 1'b1;
        RDY_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        default:    rsp_if.ready <= mask[0];
      endcase
    end
  end

  // Each response taken is compared with the oldest answer still owed.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      n_responses++;
      if (pending_found_q.size() == 0) begin
        $error("found: no search waiting for an answer, actual %0b", rsp_if.found);
        fail_count++;
      end else begin
        if (rsp_if.found !== pending_found_q[0]) begin
          $error("found: expected %0b, actual %0b", pending_found_q[0], rsp_if.found);
          fail_count++;
        end
        void'(pending_found_q.pop_front());
      end
    end
  end

  // Ends the run when neither channel has moved a request or a response for
  // far longer than any legal stall or gap.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer on either channel for %0d cycles.", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

endmodule
